// ===== hw/rtl/tcw_pkg.sv =====
// Shared types, constants and the ANSI colour table for the text console writer.
// No dependencies; tcw_ctrl, tcw_dp and the top level refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

	// default screen geometry
	localparam int DEF_COLUMNS = 80;
	localparam int DEF_ROWS    = 25;

	// request modes
	localparam logic [1:0] MODE_CHAR  = 2'd0;
	localparam logic [1:0] MODE_COLOR = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	// control bytes
	localparam logic [7:0] CHAR_LF    = 8'd10;
	localparam logic [7:0] CHAR_CR    = 8'd13;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	// SGR colour ranges
	localparam logic [7:0] SGR_FG_LO  = 8'd30;
	localparam logic [7:0] SGR_FG_HI  = 8'd37;
	localparam logic [7:0] SGR_BG_LO  = 8'd40;
	localparam logic [7:0] SGR_BG_HI  = 8'd47;
	localparam logic [7:0] SGR_BFG_LO = 8'd90;
	localparam logic [7:0] SGR_BFG_HI = 8'd97;
	localparam logic [7:0] SGR_BBG_LO = 8'd100;
	localparam logic [7:0] SGR_BBG_HI = 8'd107;

	// colours after reset
	localparam logic [3:0] FORE_RESET = 4'd7;
	localparam logic [3:0] BACK_RESET = 4'd0;

	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  char_code;
		logic [7:0]  color_code;
		logic [10:0] cell_index;
	} item_t;

	typedef struct packed {
		logic [7:0] cell_glyph;
		logic [3:0] cell_fore;
		logic [3:0] cell_back;
		logic [6:0] cursor_col;
		logic [4:0] cursor_row;
		logic       did_scroll;
	} result_t;

	typedef struct packed {
		logic [7:0] glyph;
		logic [3:0] fore;
		logic [3:0] back;
	} cell_t;

	// screen contents after reset
	localparam cell_t CELL_RESET = '{glyph: 8'd0, fore: 4'd1, back: 4'd0};

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_BLANK,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic clear_en;
		logic take_in;
		logic exec;
		logic blank_en;
		logic load_out;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] mode;
		logic       scroll;
		logic       blank_last;
		logic       clear_last;
	} status_t;

	// ANSI colour index (0-7 normal, 8-15 bright) to VGA palette index
	function automatic logic [3:0] sgr_palette(input logic [3:0] idx);
		logic [3:0] v;
		unique case (idx)
			4'd0:    v = 4'd0;
			4'd1:    v = 4'd4;
			4'd2:    v = 4'd2;
			4'd3:    v = 4'd6;
			4'd4:    v = 4'd1;
			4'd5:    v = 4'd5;
			4'd6:    v = 4'd3;
			4'd7:    v = 4'd7;
			4'd8:    v = 4'd8;
			4'd9:    v = 4'd12;
			4'd10:   v = 4'd10;
			4'd11:   v = 4'd14;
			4'd12:   v = 4'd9;
			4'd13:   v = 4'd13;
			4'd14:   v = 4'd11;
			default: v = 4'd15;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tcw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tcw_ctrl.sv =====
// Controller FSM for the text console writer: sequences clear, execute,
// row blanking and result transfer. Depends on tcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            item_valid,
	output logic                 item_ready,
	output logic                 result_valid,
	input  wire logic            result_ready,
	input  wire tcw_pkg::status_t status,
	output tcw_pkg::cmd_t        cmd
);

	tcw_pkg::state_t state_q, state_d;
	logic            out_valid_q;
	logic            slot_free;

	assign slot_free    = !out_valid_q || result_ready;
	assign result_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tcw_pkg::ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		unique case (state_q)
			tcw_pkg::ST_CLEAR: begin
				cmd.clear_en = 1'b1;
				if (status.clear_last) begin
					state_d = tcw_pkg::ST_IDLE;
				end
			end
			tcw_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.take_in = 1'b1;
					state_d     = tcw_pkg::ST_EXEC;
				end
			end
			tcw_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
				if (status.mode == tcw_pkg::MODE_READ) begin
					state_d = tcw_pkg::ST_DONE;
				end else if (status.scroll) begin
					state_d = tcw_pkg::ST_BLANK;
				end else if (slot_free) begin
					cmd.load_out = 1'b1;
					state_d      = tcw_pkg::ST_IDLE;
				end else begin
					state_d = tcw_pkg::ST_DONE;
				end
			end
			tcw_pkg::ST_BLANK: begin
				cmd.blank_en = 1'b1;
				if (status.blank_last) begin
					state_d = tcw_pkg::ST_DONE;
				end
			end
			tcw_pkg::ST_DONE: begin
				if (slot_free) begin
					cmd.load_out = 1'b1;
					state_d      = tcw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tcw_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tcw_dp.sv =====
// Datapath for the text console writer: cell RAM (ring of rows), cursor,
// colours, scroll pointer, counters and result register. Depends on tcw_pkg, tcw_ram.
`timescale 1ns / 1ps
`default_nettype none

module tcw_dp #(
	parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
	parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire tcw_pkg::cmd_t    cmd,
	output tcw_pkg::status_t      status,
	input  wire tcw_pkg::item_t   item,
	output tcw_pkg::result_t      result
);

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int ADDR_W = $clog2(CELLS);
	localparam int IDX_W  = $bits(item.cell_index);
	localparam int SUM_W  = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;
	localparam int WSUM_W = ADDR_W + 1;

	tcw_pkg::item_t   item_q;
	tcw_pkg::result_t result_q;

	logic [COL_W-1:0]  col_q, col_d;
	logic [ROW_W-1:0]  row_q, row_d;
	logic [3:0]        fore_q, fore_d, back_q, back_d;
	logic [ADDR_W-1:0] top_q, top_d;
	logic [COL_W-1:0]  blank_q;
	logic [ADDR_W-1:0] clr_q;
	logic              scroll_q, scroll_d;

	logic              is_lf, is_cr, row_inc, scroll_now, char_wr;
	logic [7:0]        code;
	logic              blank_last;

	logic [ADDR_W-1:0] char_log;
	logic [WSUM_W-1:0] char_sum;
	logic [ADDR_W-1:0] char_addr;
	logic [SUM_W-1:0]  rd_ext, rd_sum;
	logic              rd_ok;
	logic [ADDR_W-1:0] rd_addr;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	tcw_pkg::cell_t    ram_wdata, ram_rdata;

	assign code       = item_q.color_code;
	assign is_lf      = (item_q.char_code == tcw_pkg::CHAR_LF);
	assign is_cr      = (item_q.char_code == tcw_pkg::CHAR_CR);
	assign blank_last = (blank_q == COL_W'(COLUMNS - 1));

	// cursor and colour update
	always_comb begin
		col_d      = col_q;
		row_d      = row_q;
		fore_d     = fore_q;
		back_d     = back_q;
		scroll_d   = scroll_q;
		row_inc    = 1'b0;
		scroll_now = 1'b0;
		char_wr    = 1'b0;
		if (cmd.exec) begin
			scroll_d = 1'b0;
			unique case (item_q.mode)
				tcw_pkg::MODE_CHAR: begin
					if (is_lf) begin
						col_d   = '0;
						row_inc = 1'b1;
					end else if (is_cr) begin
						col_d = '0;
					end else begin
						char_wr = 1'b1;
						if (col_q == COL_W'(COLUMNS - 1)) begin
							col_d   = '0;
							row_inc = 1'b1;
						end else begin
							col_d = col_q + COL_W'(1);
						end
					end
					if (row_inc) begin
						if (row_q == ROW_W'(ROWS - 1)) begin
							scroll_now = 1'b1;
							scroll_d   = 1'b1;
						end else begin
							row_d = row_q + ROW_W'(1);
						end
					end
				end
				tcw_pkg::MODE_COLOR: begin
					if (code >= tcw_pkg::SGR_FG_LO && code <= tcw_pkg::SGR_FG_HI) begin
						fore_d = tcw_pkg::sgr_palette({1'b0, 3'(code - tcw_pkg::SGR_FG_LO)});
					end else if (code >= tcw_pkg::SGR_BG_LO && code <= tcw_pkg::SGR_BG_HI) begin
						back_d = tcw_pkg::sgr_palette({1'b0, 3'(code - tcw_pkg::SGR_BG_LO)});
					end else if (code >= tcw_pkg::SGR_BFG_LO && code <= tcw_pkg::SGR_BFG_HI) begin
						fore_d = tcw_pkg::sgr_palette({1'b1, 3'(code - tcw_pkg::SGR_BFG_LO)});
					end else if (code >= tcw_pkg::SGR_BBG_LO && code <= tcw_pkg::SGR_BBG_HI) begin
						back_d = tcw_pkg::sgr_palette({1'b1, 3'(code - tcw_pkg::SGR_BBG_LO)});
					end
				end
				default: begin
				end
			endcase
		end
	end

	// logical cell -> physical RAM address, rows rotate by top_q
	always_comb begin
		char_log  = ADDR_W'(row_q * COLUMNS) + ADDR_W'(col_q);
		char_sum  = WSUM_W'(char_log) + WSUM_W'(top_q);
		if (char_sum >= WSUM_W'(CELLS)) begin
			char_sum = char_sum - WSUM_W'(CELLS);
		end
		char_addr = ADDR_W'(char_sum);

		rd_ext = SUM_W'(item_q.cell_index);
		rd_ok  = (rd_ext < SUM_W'(CELLS));
		rd_sum = rd_ext + SUM_W'(top_q);
		if (rd_sum >= SUM_W'(CELLS)) begin
			rd_sum = rd_sum - SUM_W'(CELLS);
		end
		rd_addr = rd_ok ? ADDR_W'(rd_sum) : '0;
	end

	// RAM write port: clear pass, row blanking or character store
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = char_addr;
		ram_wdata = '{glyph: item_q.char_code, fore: fore_q, back: back_q};
		if (cmd.clear_en) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = tcw_pkg::CELL_RESET;
		end else if (cmd.blank_en) begin
			ram_we    = 1'b1;
			ram_waddr = top_q + ADDR_W'(blank_q);
			ram_wdata = '{glyph: tcw_pkg::CHAR_SPACE, fore: fore_q, back: back_q};
		end else if (char_wr) begin
			ram_we = 1'b1;
		end
	end

	always_comb begin
		top_d = top_q;
		if (cmd.blank_en && blank_last) begin
			top_d = (top_q == ADDR_W'(CELLS - COLUMNS)) ? '0 : top_q + ADDR_W'(COLUMNS);
		end
	end

	tcw_ram #(
		.WIDTH ($bits(tcw_pkg::cell_t)),
		.DEPTH (CELLS)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_addr (rd_addr),
		.rd_data (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			fore_q   <= tcw_pkg::FORE_RESET;
			back_q   <= tcw_pkg::BACK_RESET;
			top_q    <= '0;
			blank_q  <= '0;
			clr_q    <= '0;
			scroll_q <= 1'b0;
		end else begin
			col_q    <= col_d;
			row_q    <= row_d;
			fore_q   <= fore_d;
			back_q   <= back_d;
			top_q    <= top_d;
			scroll_q <= scroll_d;
			if (cmd.blank_en) begin
				blank_q <= blank_last ? '0 : blank_q + COL_W'(1);
			end
			if (cmd.clear_en) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			item_q <= item;
		end
		if (cmd.load_out) begin
			if (item_q.mode == tcw_pkg::MODE_READ && rd_ok) begin
				result_q.cell_glyph <= ram_rdata.glyph;
				result_q.cell_fore  <= ram_rdata.fore;
				result_q.cell_back  <= ram_rdata.back;
			end else begin
				result_q.cell_glyph <= '0;
				result_q.cell_fore  <= '0;
				result_q.cell_back  <= '0;
			end
			result_q.cursor_col <= 7'(col_d);
			result_q.cursor_row <= 5'(row_d);
			result_q.did_scroll <= scroll_d;
		end
	end

	assign result            = result_q;
	assign status.mode       = item_q.mode;
	assign status.scroll     = scroll_now;
	assign status.blank_last = blank_last;
	assign status.clear_last = (clr_q == ADDR_W'(CELLS - 1));

endmodule

`default_nettype wire

// ===== hw/rtl/text_console_writer_top.sv =====
// Top level of the text console writer: controller plus datapath.
// Depends on tcw_pkg, tcw_ctrl, tcw_dp (and tcw_ram below it).
`timescale 1ns / 1ps
`default_nettype none

// Text-mode console writer. Holds a COLUMNS x ROWS screen of character cells
// (glyph, foreground, background), a cursor and the current colours. Each
// request on the item channel gives exactly one transfer on the result
// channel, in order. Mode 0 writes a character: LF moves to column 0 of the
// next row, CR to column 0, any other byte (NUL included) is stored at the
// cursor in the current colours and the cursor advances, wrapping at the row
// end. Stepping past the last row scrolls the screen up one line and fills
// the bottom row with spaces in the current colours; did_scroll flags it.
// Mode 1 applies an ANSI SGR colour code (30-37, 40-47, 90-97, 100-107);
// other codes are ignored. Mode 2 reads the cell at row*COLUMNS+column;
// indices beyond the screen read as all zero. Mode 3 does nothing. Cell
// fields are zero for every mode but a read.
// Operation: after reset the block runs a clearing pass over all COLUMNS*ROWS
// cells, writing one cell per cycle, with item_ready low. After that, a
// character or colour request executes and then loads its result; a read
// first waits for the cell RAM, which has a registered read port; a request
// that scrolls adds a row of blanking writes before its result. A scroll is
// not a screen copy: the RAM is a ring of rows behind a top-of-screen
// pointer, so scrolling costs one row of blanking writes through the single
// RAM write port. One request is in flight at a time; a finished result
// waits in the output register, so the next transfer is accepted while it is
// still pending, and its completion stalls only until the result has been taken.

module text_console_writer_top #(
	parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
	parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// request channel
	input  wire logic             item_valid,
	output logic                  item_ready,
	input  wire tcw_pkg::item_t   item,
	// result channel
	output logic                  result_valid,
	input  wire logic             result_ready,
	output tcw_pkg::result_t      result
);

	tcw_pkg::cmd_t    cmd;
	tcw_pkg::status_t status;

	// sequencing: clear pass, execute, row blanking, result transfer
	tcw_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.cmd          (cmd)
	);

	// cell store, cursor, colours and result register
	tcw_dp #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.status (status),
		.item   (item),
		.result (result)
	);

endmodule

`default_nettype wire
